// ===== rtl/eoc_pkg.sv =====
// Shared types and constants for the elevator order controller.
package eoc_pkg;

	localparam int FLOORS_DEF = 4;
	localparam int FLOOR_W    = 2;
	localparam int BTN_W      = 4;
	localparam int TICK_W     = 16;
	localparam int IN_W       = 24;
	localparam int OUT_W      = 24;

	localparam logic [TICK_W-1:0] DOOR_TICKS_RST = 16'd150;

	// bit positions inside one order row
	localparam int ORD_CAB  = 0;
	localparam int ORD_UP   = 1;
	localparam int ORD_DOWN = 2;
	localparam int ORD_W    = 3;

	// heading and motor codes
	localparam logic signed [1:0] HEAD_UP   = 2'sb01;
	localparam logic signed [1:0] HEAD_NONE = 2'sb00;
	localparam logic signed [1:0] HEAD_DOWN = 2'sb11;

	typedef enum logic [2:0] {
		MODE_STARTUP    = 3'd0,
		MODE_RUN        = 3'd1,
		MODE_DOOR       = 3'd2,
		MODE_HOLD_FLOOR = 3'd3,
		MODE_HOLD_MID   = 3'd4,
		MODE_STOP_DOOR  = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		SEQ_IDLE = 2'd0,
		SEQ_REC  = 2'd1,
		SEQ_DEC  = 2'd2
	} seq_t;

	typedef struct packed {
		logic capture;
		logic record;
		logic decide;
	} ctl_cmd_t;

endpackage

// ===== rtl/eoc_ctrl.sv =====
// Sequencer for one poll sample: capture, record buttons, decide and present.
module eoc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_valid,
	output logic              s_ready,
	output logic              m_valid,
	input  logic              m_ready,
	output eoc_pkg::ctl_cmd_t cmd
);
	import eoc_pkg::*;

	seq_t seq_q, seq_d;
	logic m_valid_q, m_valid_d;
	logic m_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q     <= SEQ_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			seq_q     <= seq_d;
			m_valid_q <= m_valid_d;
		end
	end

	always_comb begin
		seq_d   = seq_q;
		cmd     = '0;
		s_ready = 1'b0;
		m_free  = !m_valid_q || m_ready;
		unique case (seq_q)
			SEQ_IDLE: begin
				s_ready = 1'b1;
				if (s_valid) begin
					cmd.capture = 1'b1;
					seq_d       = SEQ_REC;
				end
			end
			SEQ_REC: begin
				cmd.record = 1'b1;
				seq_d      = SEQ_DEC;
			end
			SEQ_DEC: begin
				// commit only when the output slot is free
				if (m_free) begin
					cmd.decide = 1'b1;
					seq_d      = SEQ_IDLE;
				end
			end
			default: begin
				seq_d = SEQ_IDLE;
			end
		endcase
		priority if (cmd.decide) begin
			m_valid_d = 1'b1;
		end else if (m_ready) begin
			m_valid_d = 1'b0;
		end else begin
			m_valid_d = m_valid_q;
		end
	end

	assign m_valid = m_valid_q;

endmodule

// ===== rtl/eoc_dp.sv =====
// Order store, heading, door timer and output register of the controller.
module eoc_dp #(
	parameter int FLOORS = eoc_pkg::FLOORS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  eoc_pkg::ctl_cmd_t           cmd,
	input  logic [eoc_pkg::IN_W-1:0]    in_data,
	input  logic                        cfg_we,
	input  logic [eoc_pkg::TICK_W-1:0]  cfg_wdata,
	output logic [eoc_pkg::OUT_W-1:0]   out_data
);
	import eoc_pkg::*;

	localparam int PADW = (FLOORS > BTN_W) ? FLOORS : BTN_W;

	// captured sample
	logic               at_q;
	logic [FLOOR_W-1:0] fl_q;
	logic [BTN_W-1:0]   up_btn_q, dn_btn_q, cab_btn_q;
	logic               stop_q, obst_q;
	logic               at_in;

	// service state
	logic [ORD_W-1:0]   store_q [FLOORS];
	logic signed [1:0]  heading_q;
	logic [FLOOR_W-1:0] last_floor_q;
	mode_t              mode_q;
	logic [TICK_W-1:0]  timer_q;
	logic [TICK_W-1:0]  door_ticks_q;
	logic [OUT_W-1:0]   out_q;

	// record step
	logic [PADW-1:0]    up_ext, dn_ext, cab_ext;
	logic [ORD_W-1:0]   rec_row [FLOORS];
	logic               rec_en;

	// decide step
	logic [FLOORS-1:0]  nz;
	logic               any_ord, above, below, single, stop_here;
	logic [ORD_W-1:0]   row_sel;
	logic signed [1:0]  head_new;
	logic [TICK_W-1:0]  door_start, tick_timer;
	logic               tick_close;
	logic [ORD_W-1:0]   store_d [FLOORS];
	logic signed [1:0]  heading_d;
	logic [FLOOR_W-1:0] last_floor_d;
	mode_t              mode_d;
	logic [TICK_W-1:0]  timer_d;
	logic signed [1:0]  motor;
	logic               door, slamp;
	logic [PADW-1:0]    up_l, dn_l, cab_l;
	logic [OUT_W-1:0]   out_d;

	assign at_in = in_data[0] && (int'(in_data[2:1]) < FLOORS);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			at_q      <= at_in;
			fl_q      <= in_data[2:1];
			up_btn_q  <= in_data[6:3];
			dn_btn_q  <= in_data[10:7];
			cab_btn_q <= in_data[14:11];
			stop_q    <= in_data[15];
			obst_q    <= in_data[16];
		end
		if (cmd.decide) begin
			out_q <= out_d;
		end
	end

	// merge pressed buttons into the rows, only in run mode or door mode
	assign up_ext  = PADW'(up_btn_q);
	assign dn_ext  = PADW'(dn_btn_q);
	assign cab_ext = PADW'(cab_btn_q);
	assign rec_en  = (mode_q == MODE_RUN) || (mode_q == MODE_DOOR);

	always_comb begin
		for (int i = 0; i < FLOORS; i++) begin
			rec_row[i] = store_q[i];
			if (rec_en) begin
				rec_row[i][ORD_CAB]  = store_q[i][ORD_CAB]  | cab_ext[i];
				rec_row[i][ORD_UP]   = store_q[i][ORD_UP]   | up_ext[i];
				rec_row[i][ORD_DOWN] = store_q[i][ORD_DOWN] | dn_ext[i];
			end
		end
	end

	// scan of the rows: occupancy at or above and at or below the last floor, and the row of the sensed floor
	always_comb begin
		above   = 1'b0;
		below   = 1'b0;
		row_sel = '0;
		for (int i = 0; i < FLOORS; i++) begin
			nz[i] = |store_q[i];
			if (i >= int'(last_floor_q)) above = above | nz[i];
			if (i <= int'(last_floor_q)) below = below | nz[i];
			if (i == int'(fl_q)) row_sel = store_q[i];
		end
		any_ord = |nz;
		single  = any_ord && ((nz & (nz - FLOORS'(1))) == '0);
	end

	always_comb begin
		head_new = heading_q;
		if (int'(last_floor_q) >= FLOORS - 1) begin
			head_new = HEAD_DOWN;
		end else if (last_floor_q == '0) begin
			head_new = HEAD_UP;
		end else begin
			if (head_new == HEAD_UP && !above) begin
				head_new = HEAD_NONE;
			end else if (head_new == HEAD_DOWN && !below) begin
				head_new = HEAD_NONE;
			end
			if (head_new == HEAD_NONE && above) begin
				head_new = HEAD_UP;
			end else if (head_new == HEAD_NONE && below) begin
				head_new = HEAD_DOWN;
			end
		end
		priority if (single) begin
			stop_here = |row_sel;
		end else if (head_new == HEAD_DOWN) begin
			stop_here = row_sel[ORD_CAB] | row_sel[ORD_DOWN];
		end else if (head_new == HEAD_UP) begin
			stop_here = row_sel[ORD_CAB] | row_sel[ORD_UP];
		end else begin
			stop_here = 1'b0;
		end
	end

	// door timer: reload while obstructed, close when it runs out
	assign door_start = (door_ticks_q == '0) ? TICK_W'(1) : door_ticks_q;
	assign tick_close = !obst_q && (timer_q <= TICK_W'(1));
	assign tick_timer = obst_q ? door_start : (tick_close ? '0 : timer_q - TICK_W'(1));

	always_comb begin
		store_d      = store_q;
		heading_d    = heading_q;
		last_floor_d = last_floor_q;
		mode_d       = mode_q;
		timer_d      = timer_q;
		motor        = HEAD_NONE;
		door         = 1'b0;
		slamp        = 1'b0;
		unique case (mode_q)
			MODE_STARTUP: begin
				motor = HEAD_DOWN;
				if (at_q) begin
					last_floor_d = fl_q;
					if (fl_q == '0) begin
						motor  = HEAD_NONE;
						mode_d = MODE_RUN;
					end
				end
			end
			MODE_DOOR: begin
				door    = 1'b1;
				timer_d = tick_timer;
				if (tick_close) begin
					for (int i = 0; i < FLOORS; i++) begin
						if (i == int'(last_floor_q)) store_d[i] = '0;
					end
					door   = 1'b0;
					mode_d = MODE_RUN;
				end
			end
			MODE_HOLD_FLOOR: begin
				door = 1'b1;
				if (stop_q) begin
					slamp = 1'b1;
				end else begin
					timer_d = door_start;
					mode_d  = MODE_STOP_DOOR;
				end
			end
			MODE_HOLD_MID: begin
				if (stop_q) begin
					slamp = 1'b1;
				end else begin
					mode_d = MODE_RUN;
				end
			end
			MODE_STOP_DOOR: begin
				door    = 1'b1;
				timer_d = tick_timer;
				if (tick_close) begin
					door   = 1'b0;
					mode_d = MODE_RUN;
				end
			end
			default: begin
				mode_d    = MODE_RUN;
				heading_d = head_new;
				motor     = any_ord ? head_new : HEAD_NONE;
				if (stop_q) begin
					for (int i = 0; i < FLOORS; i++) store_d[i] = '0;
					heading_d = HEAD_NONE;
					motor     = HEAD_NONE;
					slamp     = 1'b1;
					if (at_q) begin
						last_floor_d = fl_q;
						door         = 1'b1;
						mode_d       = MODE_HOLD_FLOOR;
					end else begin
						mode_d = MODE_HOLD_MID;
					end
				end else if (at_q) begin
					if (stop_here) begin
						motor   = HEAD_NONE;
						door    = 1'b1;
						timer_d = door_start;
						mode_d  = MODE_DOOR;
					end
					last_floor_d = fl_q;
				end
			end
		endcase

		up_l  = '0;
		dn_l  = '0;
		cab_l = '0;
		for (int i = 0; i < FLOORS; i++) begin
			up_l[i]  = store_d[i][ORD_UP];
			dn_l[i]  = store_d[i][ORD_DOWN];
			cab_l[i] = store_d[i][ORD_CAB];
		end
		out_d = OUT_W'({last_floor_d, cab_l[BTN_W-1:0], dn_l[BTN_W-1:0],
			up_l[BTN_W-1:0], slamp, door, motor});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FLOORS; i++) store_q[i] <= '0;
			heading_q    <= HEAD_UP;
			last_floor_q <= '0;
			mode_q       <= MODE_STARTUP;
			timer_q      <= '0;
			door_ticks_q <= DOOR_TICKS_RST;
		end else begin
			if (cfg_we) begin
				door_ticks_q <= cfg_wdata;
			end
			if (cmd.record) begin
				store_q <= rec_row;
			end else if (cmd.decide) begin
				store_q      <= store_d;
				heading_q    <= heading_d;
				last_floor_q <= last_floor_d;
				mode_q       <= mode_d;
				timer_q      <= timer_d;
			end
		end
	end

	assign out_data = out_q;

endmodule

// ===== rtl/elevator_order_controller_top.sv =====
// Top level of the elevator order controller: sequencer plus datapath.
//
//  channel   direction  transfer carries
//  s_axis    in         one poll sample: sensor, buttons, stop, obstruction
//  m_axis    out        one set of motor, door, stop and order lamp outputs
//  cfg       in         door_ticks, written with cfg_we, no read-back
//
// Each sample passes through capture at the transfer edge, a record step that
// merges the buttons into the order rows, and a decide step that picks heading
// and stop from the order-row scan and loads the output register.
// Reset clears the orders, points the heading up and starts the descent to
// the bottom floor; door_ticks returns to 150.
// A result waiting on m_axis does not block the next sample's transfer; the
// decide cycle holds until the output register is free.
module elevator_order_controller_top #(
	parameter int FLOORS = eoc_pkg::FLOORS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// [0] at_floor, [2:1] floor_index, [6:3] hall_up_buttons,
	// [10:7] hall_down_buttons, [14:11] cab_buttons, [15] stop_pressed,
	// [16] obstructed, [23:17] zero
	input  logic [eoc_pkg::IN_W-1:0]    s_axis_tdata,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// [1:0] motor_dir, [2] door_lamp, [3] stop_lamp, [7:4] up_lamps,
	// [11:8] down_lamps, [15:12] cab_lamps, [17:16] floor_lamp, [23:18] zero
	output logic [eoc_pkg::OUT_W-1:0]   m_axis_tdata,
	input  logic                        cfg_we,
	input  logic [eoc_pkg::TICK_W-1:0]  cfg_wdata
);
	import eoc_pkg::*;

	ctl_cmd_t cmd;

	// sequencer: hands capture, record and decide steps to the datapath
	eoc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.cmd     (cmd)
	);

	// datapath: order rows, heading, door timer, output register
	eoc_dp #(
		.FLOORS (FLOORS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (s_axis_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_data  (m_axis_tdata)
	);

endmodule

// ===== rtl/eoc_checker.sv =====
// Port-level checks for the elevator order controller, bound to the top level.
module eoc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_axis_tvalid,
	input logic                        s_axis_tready,
	input logic                        m_axis_tvalid,
	input logic                        m_axis_tready,
	input logic [eoc_pkg::OUT_W-1:0]   m_axis_tdata
);
	import eoc_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// one sample at a time: no transfer right after a transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input ready right after a transfer");

	// motor code is never the unused pattern
	a_motor_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[1:0] != 2'b10)
		else $error("illegal motor code");

	// door open means motor stopped
	a_door_still: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1:0] == 2'b00)
		else $error("motor moving with door open");

	// stop lamp lit means no orders pending
	a_stop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[15:4] == 12'd0)
		else $error("orders pending while stop lamp lit");

endmodule

bind elevator_order_controller_top eoc_checker u_eoc_checker (.*);
